FILE: sv/lz77_varint_token_decompressor_defines.svh
// ----------------------------------------------------------------------------
// lz77 decompressor assertion macros
// shared concurrent assertion forms, clocked on clk, reset on rst
// ----------------------------------------------------------------------------
`ifndef LZ77_VARINT_TOKEN_DECOMPRESSOR_DEFINES_SVH
`define LZ77_VARINT_TOKEN_DECOMPRESSOR_DEFINES_SVH

// property holds at every clock edge out of reset
`define LZD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// types and constants of the lz77 token decompressor
// ----------------------------------------------------------------------------
package lzd_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC    = 4'd0,
    PH_SIZE     = 4'd1,
    PH_TYPE     = 4'd2,
    PH_LIT_LEN  = 4'd3,
    PH_LIT_DATA = 4'd4,
    PH_REF_OFF  = 4'd5,
    PH_REF_LEN  = 4'd6,
    PH_DONE     = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_WR   = 2'd2,
    S_EMIT = 2'd3
  } st_t;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_TYPE    = 3'd2;
  localparam logic [2:0] ERR_VARINT  = 3'd3;
  localparam logic [2:0] ERR_OFFSET  = 3'd4;
  localparam logic [2:0] ERR_OVERRUN = 3'd5;
  localparam logic [2:0] ERR_TRUNC   = 3'd6;
  localparam logic [2:0] ERR_COPY    = 3'd7;

  localparam logic [7:0] MAGIC_0   = 8'h4D;
  localparam logic [7:0] MAGIC_1   = 8'h4F;
  localparam logic [7:0] MAGIC_2   = 8'h43;
  localparam logic [7:0] FMT_LEG   = 8'h33;
  localparam logic [7:0] FMT_VAR   = 8'h35;
  localparam logic [7:0] TYPE_LIT  = 8'h00;
  localparam logic [7:0] TYPE_REF  = 8'h01;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic [2:0]  out_count;
    logic        out_last;
    logic        done_res;
    logic [2:0]  error_code;
    logic [31:0] total_written;
  } out_word_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MAGIC_0;
      2'd1:    m = MAGIC_1;
      default: m = MAGIC_2;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/lz77_varint_token_decompressor.sv
// ----------------------------------------------------------------------------
// lz77_varint_token_decompressor
// byte-serial lz77 token decoder with varint or fixed counts and history ram
// ----------------------------------------------------------------------------
//  channel | ports                          | word
//  --------+--------------------------------+------------------------------
//  input   | din, din_valid, din_ready      | in_word_t : one stream byte
//  output  | dout, dout_valid, dout_ready   | out_word_t: up to lane bytes
//
//  header, token, literal bytes: one output word each unless starting a copy
//  back-reference: an S_RD and an S_WR state per copied byte, an S_EMIT state
//    per word; the history ram is read, then written, for every copied byte
//  reset (rst, synchronous) clears all control state; the history ram is
//    not cleared, offset checks keep reads inside written entries
//  a full output register stalls the input and the copy engine alike
// ----------------------------------------------------------------------------
`include "lz77_varint_token_decompressor_defines.svh"

module lz77_varint_token_decompressor
  import lzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536,
  parameter int MAX_COPY      = 256,
  parameter int LANE_BYTES    = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  din,
  input  logic      din_valid,
  output logic      din_ready,
  output out_word_t dout,
  output logic      dout_valid,
  input  logic      dout_ready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int LW = $clog2(MAX_COPY + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [2:0] LANE_W   = 3'(LANE_BYTES);

  // history ram
  logic [7:0]    mem [HISTORY_DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          we;

  // parser state
  phase_t      phase, phase_next;
  logic [2:0]  hidx, hidx_next;
  logic        legacy, legacy_next;
  logic [31:0] dsize, dsize_next;
  logic [31:0] wc, wc_next;
  logic [31:0] acc, acc_next;
  logic [2:0]  fidx, fidx_next;
  logic [31:0] offset, offset_next;
  logic [31:0] lrem, lrem_next;
  logic [2:0]  err, err_next;
  logic [AW-1:0] wp;

  // copy engine
  st_t          st, st_next;
  logic [LW-1:0] cleft;
  logic [31:0]  lane;
  logic [2:0]   lcnt;

  logic        take;
  logic        lit_emit;
  logic        copy_go;
  logic [31:0] copy_len;
  logic        out_free;

  assign out_free  = !dout_valid || dout_ready;
  assign din_ready = (st == S_IDLE) && out_free;
  assign take      = din_valid && din_ready;

  // ---------------- parser: next state for one accepted byte ----------------
  always_comb begin
    logic [7:0]  b;
    logic [31:0] val;
    logic        fdone;
    b           = din.in_byte;
    val         = '0;
    fdone       = 1'b0;
    phase_next  = phase;
    hidx_next   = hidx;
    legacy_next = legacy;
    dsize_next  = dsize;
    wc_next     = wc;
    acc_next    = acc;
    fidx_next   = fidx;
    offset_next = offset;
    lrem_next   = lrem;
    err_next    = err;
    lit_emit    = 1'b0;
    copy_go     = 1'b0;
    copy_len    = '0;
    if (err == ERR_NONE && phase != PH_DONE) begin
      case (phase)
        PH_MAGIC: begin
          if (hidx < 3'd3) begin
            if (b != magic_byte(hidx[1:0])) err_next = ERR_MAGIC;
            else hidx_next = hidx + 3'd1;
          end else if (b == FMT_LEG || b == FMT_VAR) begin
            legacy_next = (b == FMT_LEG);
            hidx_next   = '0;
            dsize_next  = '0;
            phase_next  = PH_SIZE;
          end else begin
            err_next = ERR_MAGIC;
          end
        end
        PH_SIZE: begin
          dsize_next = dsize | (32'(b) << {hidx[1:0], 3'b000});
          if (hidx >= 3'd3) begin
            hidx_next  = '0;
            phase_next = (dsize_next == '0) ? PH_DONE : PH_TYPE;
          end else begin
            hidx_next = hidx + 3'd1;
          end
        end
        PH_TYPE: begin
          acc_next  = '0;
          fidx_next = '0;
          if (b == TYPE_LIT) phase_next = PH_LIT_LEN;
          else if (b == TYPE_REF) phase_next = PH_REF_OFF;
          else err_next = ERR_TYPE;
        end
        PH_LIT_LEN, PH_REF_OFF, PH_REF_LEN: begin
          if (legacy) begin
            acc_next = acc | (32'(b) << {fidx[1:0], 3'b000});
            if (fidx >= 3'd3) begin
              fdone = 1'b1;
              val   = acc_next;
            end else begin
              fidx_next = fidx + 3'd1;
            end
          end else if (fidx >= 3'd4) begin
            if (b[7:4] != 4'd0) begin
              err_next = ERR_VARINT;
            end else begin
              fdone = 1'b1;
              val   = acc | {b[3:0], 28'd0};
            end
          end else begin
            case (fidx[1:0])
              2'd0:    acc_next = acc | 32'(b[6:0]);
              2'd1:    acc_next = acc | (32'(b[6:0]) << 7);
              2'd2:    acc_next = acc | (32'(b[6:0]) << 14);
              default: acc_next = acc | (32'(b[6:0]) << 21);
            endcase
            if (b[7]) fidx_next = fidx + 3'd1;
            else begin
              fdone = 1'b1;
              val   = acc_next;
            end
          end
          if (fdone) begin
            case (phase)
              PH_LIT_LEN: begin
                if ({1'b0, wc} + {1'b0, val} > {1'b0, dsize}) err_next = ERR_OVERRUN;
                else begin
                  lrem_next = val;
                  if (val == '0) phase_next = (wc == dsize) ? PH_DONE : PH_TYPE;
                  else phase_next = PH_LIT_DATA;
                end
              end
              PH_REF_OFF: begin
                offset_next = val;
                acc_next    = '0;
                fidx_next   = '0;
                phase_next  = PH_REF_LEN;
              end
              default: begin
                if (offset == '0 || offset > wc ||
                    {1'b0, offset} > 33'(HISTORY_DEPTH)) begin
                  err_next = ERR_OFFSET;
                end else if ({1'b0, wc} + {1'b0, val} > {1'b0, dsize}) begin
                  err_next = ERR_OVERRUN;
                end else if (val > 32'(MAX_COPY)) begin
                  err_next = ERR_COPY;
                end else begin
                  // counter advances as the engine writes; phase settles now
                  copy_go    = (val != '0);
                  copy_len   = val;
                  phase_next = (wc + val == dsize) ? PH_DONE : PH_TYPE;
                end
              end
            endcase
          end
        end
        PH_LIT_DATA: begin
          lit_emit  = 1'b1;
          wc_next   = wc + 32'd1;
          lrem_next = lrem - 32'd1;
          if (lrem_next == '0) phase_next = (wc_next == dsize) ? PH_DONE : PH_TYPE;
        end
        default: ;
      endcase
      // stream ended before the declared size was produced
      if (err_next == ERR_NONE && phase_next != PH_DONE && din.in_last)
        err_next = ERR_TRUNC;
    end
  end

  // ---------------- copy engine: next state ----------------
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: if (take && copy_go) st_next = S_RD;
      S_RD:   st_next = S_WR;
      S_WR: begin
        if (lcnt + 3'd1 == LANE_W || cleft == LW'(1)) st_next = S_EMIT;
        else st_next = S_RD;
      end
      S_EMIT: begin
        if (out_free) st_next = (cleft == '0) ? S_IDLE : S_RD;
      end
      default: st_next = S_IDLE;
    endcase
  end

  // ---------------- ram port control ----------------
  always_comb begin
    logic [AW:0] wpx;
    logic [AW:0] offx;
    wpx  = {1'b0, wp};
    offx = offset[AW:0];
    // source lies offset bytes behind the write pointer, around the ring
    if (wpx >= offx) raddr = AW'(wpx - offx);
    else raddr = AW'(wpx + DEPTH_W - offx);
    waddr = wp;
    if (st == S_WR) begin
      we    = 1'b1;
      wdata = rdata;
    end else begin
      we    = take && lit_emit;
      wdata = din.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      phase  <= PH_MAGIC;
      hidx   <= '0;
      legacy <= 1'b0;
      dsize  <= '0;
      wc     <= '0;
      acc    <= '0;
      fidx   <= '0;
      offset <= '0;
      lrem   <= '0;
      err    <= ERR_NONE;
      wp     <= '0;
      cleft  <= '0;
      lane   <= '0;
      lcnt   <= '0;
    end else begin
      st <= st_next;
      if (take) begin
        phase  <= phase_next;
        hidx   <= hidx_next;
        legacy <= legacy_next;
        dsize  <= dsize_next;
        wc     <= wc_next;
        acc    <= acc_next;
        fidx   <= fidx_next;
        offset <= offset_next;
        lrem   <= lrem_next;
        err    <= err_next;
        if (copy_go) begin
          cleft <= LW'(copy_len);
          lane  <= '0;
          lcnt  <= '0;
        end
      end
      if (we) wp <= (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + AW'(1);
      if (st == S_WR) begin
        wc    <= wc + 32'd1;
        cleft <= cleft - LW'(1);
        lane  <= lane | (32'(rdata) << {lcnt, 3'b000});
        lcnt  <= lcnt + 3'd1;
      end
      if (st == S_EMIT && out_free) begin
        lane <= '0;
        lcnt <= '0;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (take && !copy_go) begin
      dout_valid <= 1'b1;
    end else if (st == S_EMIT && out_free) begin
      dout_valid <= 1'b1;
    end else if (dout_ready) begin
      dout_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !copy_go) begin
      // single word: a literal byte or a word with no bytes
      dout.out_data      <= lit_emit ? 32'(din.in_byte) : '0;
      dout.out_count     <= lit_emit ? 3'd1 : 3'd0;
      dout.out_last      <= 1'b1;
      dout.done_res      <= (err_next == ERR_NONE) && (phase_next == PH_DONE);
      dout.error_code    <= err_next;
      dout.total_written <= wc_next;
    end else if (st == S_EMIT && out_free) begin
      dout.out_data      <= lane;
      dout.out_count     <= lcnt;
      dout.out_last      <= (cleft == '0);
      dout.done_res      <= (cleft == '0) && (err == ERR_NONE) && (phase == PH_DONE);
      dout.error_code    <= (cleft == '0) ? err : ERR_NONE;
      dout.total_written <= wc;
    end
  end

  // ---------------- assertions ----------------
  `LZD_ASSERT(a_no_take_in_copy, (st != S_IDLE) |-> !din_ready,
              "input taken while copy engine busy")
  `LZD_ASSERT(a_lane_bound, dout_valid |-> (dout.out_count <= LANE_W),
              "output word holds more bytes than a lane")
  `LZD_ASSERT_NEXT(a_err_sticky, (err != ERR_NONE), (err == $past(err)),
                   "sticky error changed before reset")

endmodule

FILE: test/tb_lz77_varint_token_decompressor.sv
// ----------------------------------------------------------------------------
// tb_lz77_varint_token_decompressor
// drives one compressed stream through the decoder in several segments; the
// decoder is predicted in the scoreboard and every output word is compared
// in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lz77_varint_token_decompressor;
  import lzd_pkg::*;

  localparam int HIST  = 65536;
  localparam int MAXCP = 256;
  localparam int LANES = 4;
  localparam int DSIZE = 1080;

  // expected output words, checked in order
  class lzd_scoreboard;
    out_word_t   pending[$];
    phase_t      ph;
    int unsigned hdr_idx;
    bit          legacy;
    logic [31:0] dsize, wcount, acc, coff, lit_left;
    int unsigned fidx;
    logic [2:0]  err;
    logic [7:0]  hist[int];
    int          n_fail;

    function void clear();
      ph = PH_MAGIC; hdr_idx = 0; legacy = 0; dsize = 0; wcount = 0;
      acc = 0; fidx = 0; coff = 0; lit_left = 0; err = ERR_NONE;
      n_fail = 0;
    endfunction

    task report_mismatch(string what, logic [31:0] want, out_word_t got);
      n_fail++;
      $display("mismatch %s: want %0h got data %0h cnt %0d last %0b done %0b err %0d tot %0d",
               what, want, got.out_data, got.out_count, got.out_last, got.done_res,
               got.error_code, got.total_written);
    endtask

    function void push_word(logic [31:0] d, logic [2:0] c);
      out_word_t w;
      w = '0;
      w.out_data = d; w.out_count = c; w.total_written = wcount;
      pending.push_back(w);
    endfunction

    function void store(logic [7:0] b);
      hist[wcount % HIST] = b;
      wcount++;
    endfunction

    function void end_token();
      ph = (wcount == dsize) ? PH_DONE : PH_TYPE;
    endfunction

    function void copy_bytes(logic [31:0] len);
      logic [31:0] lane;
      int unsigned cnt;
      logic [7:0]  b;
      lane = 0; cnt = 0;
      for (int unsigned i = 0; i < len; i++) begin
        b = hist[(wcount - coff) % HIST];
        store(b);
        lane |= 32'(b) << (8 * cnt);
        cnt++;
        if (cnt == LANES) begin
          push_word(lane, 3'(cnt));
          lane = 0; cnt = 0;
        end
      end
      if (cnt != 0) push_word(lane, 3'(cnt));
    endfunction

    function void field_complete(logic [31:0] v);
      if (ph == PH_LIT_LEN) begin
        if (64'(wcount) + 64'(v) > 64'(dsize)) begin err = ERR_OVERRUN; return; end
        lit_left = v;
        if (v == 0) end_token();
        else ph = PH_LIT_DATA;
      end else if (ph == PH_REF_OFF) begin
        coff = v; acc = 0; fidx = 0; ph = PH_REF_LEN;
      end else begin
        if (coff == 0 || coff > wcount || coff > HIST) begin err = ERR_OFFSET; return; end
        if (64'(wcount) + 64'(v) > 64'(dsize)) begin err = ERR_OVERRUN; return; end
        if (v > MAXCP) begin err = ERR_COPY; return; end
        copy_bytes(v);
        end_token();
      end
    endfunction

    function void count_byte(logic [7:0] b);
      if (legacy) begin
        acc |= 32'(b) << (8 * (fidx & 3));
        if (fidx >= 3) field_complete(acc);
        else fidx++;
        return;
      end
      if (fidx >= 4) begin
        if (b[7] || b[6:4] != 0) begin err = ERR_VARINT; return; end
        field_complete(acc | (32'(b[3:0]) << 28));
        return;
      end
      acc |= 32'(b[6:0]) << (7 * fidx);
      if (b[7]) fidx++;
      else field_complete(acc);
    endfunction

    function void decode_byte(logic [7:0] b);
      case (ph)
        PH_MAGIC: begin
          if (hdr_idx < 3) begin
            if (b != magic_byte(2'(hdr_idx))) begin err = ERR_MAGIC; return; end
            hdr_idx++;
          end else begin
            if (b == FMT_LEG) legacy = 1;
            else if (b == FMT_VAR) legacy = 0;
            else begin err = ERR_MAGIC; return; end
            hdr_idx = 0; dsize = 0; ph = PH_SIZE;
          end
        end
        PH_SIZE: begin
          dsize |= 32'(b) << (8 * (hdr_idx & 3));
          if (hdr_idx >= 3) begin
            hdr_idx = 0;
            ph = (dsize == 0) ? PH_DONE : PH_TYPE;
          end else hdr_idx++;
        end
        PH_TYPE: begin
          if (b == TYPE_LIT) begin acc = 0; fidx = 0; ph = PH_LIT_LEN; end
          else if (b == TYPE_REF) begin acc = 0; fidx = 0; ph = PH_REF_OFF; end
          else err = ERR_TYPE;
        end
        PH_LIT_LEN, PH_REF_OFF, PH_REF_LEN: count_byte(b);
        PH_LIT_DATA: begin
          store(b);
          push_word(32'(b), 3'd1);
          lit_left--;
          if (lit_left == 0) end_token();
        end
        default: ;
      endcase
    endfunction

    // note an accepted input word and queue what it should produce
    function void note_input(in_word_t w);
      int n0;
      n0 = pending.size();
      if (err == ERR_NONE && ph != PH_DONE) begin
        decode_byte(w.in_byte);
        if (err == ERR_NONE && ph != PH_DONE && w.in_last) err = ERR_TRUNC;
      end
      if (pending.size() == n0) push_word(32'd0, 3'd0);
      pending[$].out_last = 1'b1;
      pending[$].done_res = (err == ERR_NONE && ph == PH_DONE);
      pending[$].error_code = err;
    endfunction

    task check_output(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", 0, got);
        return;
      end
      want = pending.pop_front();
      if (got.out_data !== want.out_data)
        report_mismatch("out_data", want.out_data, got);
      if (got.out_count !== want.out_count)
        report_mismatch("out_count", want.out_count, got);
      if (got.out_last !== want.out_last)
        report_mismatch("out_last", want.out_last, got);
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", want.done_res, got);
      if (got.error_code !== want.error_code)
        report_mismatch("error_code", want.error_code, got);
      if (got.total_written !== want.total_written)
        report_mismatch("total_written", want.total_written, got);
    endtask
  endclass

  logic      clk;
  logic      rst;
  in_word_t  din;
  logic      din_valid;
  logic      din_ready;
  out_word_t dout;
  logic      dout_valid;
  logic      dout_ready;

  lzd_scoreboard sb;
  bit            idle_on;      // random idling enabled
  bit            hold_rx;      // long receiver hold-off request

  lz77_varint_token_decompressor dut (
    .clk(clk), .rst(rst),
    .din(din), .din_valid(din_valid), .din_ready(din_ready),
    .dout(dout), .dout_valid(dout_valid), .dout_ready(dout_ready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // stream segment under construction, one entry per input word
  logic [7:0] strm[$];

  // valid drops only when an idle gap follows; the segment end drops it too
  task automatic send_word(logic [7:0] b, bit last);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      din_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_valid <= 1'b1;
    din.in_byte <= b;
    din.in_last <= last;
    do @(posedge clk); while (!din_ready);
    sb.note_input('{in_byte: b, in_last: last});
  endtask

  // ends marks the final segment, whose last byte carries in_last
  task automatic send_stream(bit ends);
    int n;
    n = strm.size();
    for (int i = 0; i < n; i++) send_word(strm[i], ends && (i == n - 1));
    din_valid <= 1'b0;
    strm.delete();
  endtask

  task automatic wait_drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // magic, format byte and little-endian declared size
  task automatic add_header(bit legacy_fmt, logic [31:0] size);
    strm.push_back(MAGIC_0); strm.push_back(MAGIC_1); strm.push_back(MAGIC_2);
    strm.push_back(legacy_fmt ? FMT_LEG : FMT_VAR);
    for (int i = 0; i < 4; i++) strm.push_back(size[8*i +: 8]);
  endtask

  task automatic add_count(bit legacy_fmt, logic [31:0] v);
    if (legacy_fmt) begin
      for (int i = 0; i < 4; i++) strm.push_back(v[8*i +: 8]);
    end else begin
      do begin
        strm.push_back({v > 127, v[6:0]});
        v = v >> 7;
      end while (v != 0);
    end
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int gap;
    dout_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        dout_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        dout_ready <= 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap - 1) @(posedge clk);
      end else dout_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && dout_valid && dout_ready) sb.check_output(dout);
  end

  initial begin
    #50ms;
    $display("FAIL lz77_varint_token_decompressor");
    $finish;
  end

  initial begin
    int lit_n, cp_n, sz;
    bit fmt;
    sb = new();
    sb.clear();
    idle_on = 1;
    hold_rx = 0;
    rst = 1'b1;
    din = '0;
    din_valid = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one varint stream sent in segments: extreme bytes, a multi-byte
    // varint, overlapping copies, a zero-length token and trailing bytes
    fmt = 0;
    sz  = 0;
    add_header(fmt, 32'(DSIZE));
    strm.push_back(TYPE_LIT); add_count(fmt, 4);
    strm.push_back(8'h00); strm.push_back(8'hFF);
    strm.push_back(8'h55); strm.push_back(8'hAA);
    sz = 4;
    strm.push_back(TYPE_LIT); add_count(fmt, 0);
    strm.push_back(TYPE_REF); add_count(fmt, 1); add_count(fmt, 7);
    strm.push_back(TYPE_REF); add_count(fmt, 4); add_count(fmt, 200);
    sz += 207;
    send_stream(1'b0);
    wait_drain();

    // long receiver hold-off while the sender keeps offering
    hold_rx = 1;
    strm.push_back(TYPE_REF); add_count(fmt, 11); add_count(fmt, 32'(MAXCP));
    sz += MAXCP;
    for (int k = 0; k < 6; k++) begin
      strm.push_back(TYPE_REF); add_count(fmt, 1 + $urandom_range(0, 100));
      add_count(fmt, 60);
      sz += 60;
    end
    send_stream(1'b0);
    wait_drain();

    // random well-formed tokens with random content, idling stops midway
    for (int k = 0; k < 10; k++) begin
      if ($urandom_range(0, 1)) begin
        lit_n = $urandom_range(1, 8);
        strm.push_back(TYPE_LIT); add_count(fmt, 32'(lit_n));
        for (int i = 0; i < lit_n; i++) strm.push_back(8'($urandom));
        sz += lit_n;
      end else begin
        cp_n = $urandom_range(0, 20);
        strm.push_back(TYPE_REF); add_count(fmt, $urandom_range(1, sz));
        add_count(fmt, 32'(cp_n));
        sz += cp_n;
      end
      if (k == 5) begin
        send_stream(1'b0);
        wait_drain();
        idle_on = 0;
      end
    end

    // finish exactly at the declared size, then bytes that are ignored
    strm.push_back(TYPE_REF); add_count(fmt, 1); add_count(fmt, 32'(DSIZE - sz));
    for (int i = 0; i < 4; i++) strm.push_back(8'($urandom));
    send_stream(1'b1);
    wait_drain();

    if (sb.n_fail == 0 && sb.pending.size() == 0)
      $display("PASS lz77_varint_token_decompressor");
    else
      $display("FAIL lz77_varint_token_decompressor");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lzd_pkg.sv
sv/lz77_varint_token_decompressor.sv
test/tb_lz77_varint_token_decompressor.sv
